>>> src/hbcd_pkg.sv
// hbcd_pkg: shared types, codes and per-pixel color functions of the
// hi-res byte color decoder. No dependencies.
`default_nettype none

package hbcd_pkg;

   typedef logic [2:0] color_type;
   typedef logic [1:0] mode_type;
   typedef logic [6:0][2:0] pix_row_type;

   localparam color_type C_BLACK  = 3'd0;
   localparam color_type C_WHITE  = 3'd1;
   localparam color_type C_PURPLE = 3'd2;
   localparam color_type C_GREEN  = 3'd3;
   localparam color_type C_BLUE   = 3'd4;
   localparam color_type C_RED    = 3'd5;

   localparam mode_type MODE_MONO   = 2'd0;
   localparam mode_type MODE_COLOR  = 2'd1;
   localparam mode_type MODE_INTERP = 2'd2;
   localparam mode_type MODE_RESET  = MODE_COLOR;

   localparam int PIX_COUNT = 7;
   localparam int GROUP_BIT = 7;   // bit 7 of the byte, mask 0x80
   localparam logic [6:0] ODD_POS = 7'b0101010;

   typedef struct packed {
      logic [7:0] pattern_byte;
      logic       column_odd;
   } req_type;

   typedef struct packed {
      color_type pixel_color_0;
      color_type pixel_color_1;
      color_type pixel_color_2;
      color_type pixel_color_3;
      color_type pixel_color_4;
      color_type pixel_color_5;
      color_type pixel_color_6;
   } rsp_type;

   // Raw colors before mode handling: runs of two or more set bits are white.
   function automatic pix_row_type base_colors(logic [7:0] b, logic odd);
      logic [8:0]  ext;
      pix_row_type px;
      color_type   pg;
      color_type   pb;
      ext = {1'b0, b[6:0], 1'b0};
      pg  = b[GROUP_BIT] ? C_RED  : C_GREEN;
      pb  = b[GROUP_BIT] ? C_BLUE : C_PURPLE;
      for (int k = 0; k < PIX_COUNT; k++) begin
         if (!ext[k+1]) begin
            px[k] = C_BLACK;
         end else if (ext[k] || ext[k+2]) begin
            px[k] = C_WHITE;
         end else begin
            px[k] = (ODD_POS[k] != odd) ? pg : pb;
         end
      end
      return px;
   endfunction

   // Gap fill for a black pixel between left and right neighbors.
   function automatic color_type gap_fill(color_type l, color_type r, color_type fill);
      color_type c;
      if (l != C_BLACK && r != C_BLACK && (l != C_WHITE || r != C_WHITE)) begin
         c = (l != C_WHITE) ? l : r;
      end else if (l == C_WHITE && r == C_WHITE) begin
         c = fill;
      end else begin
         c = C_BLACK;
      end
      return c;
   endfunction

endpackage

`default_nettype wire

>>> src/hbcd_req_if.sv
// hbcd_req_if: input item channel (valid/ready plus byte and column parity).
// Depends on hbcd_pkg.
`default_nettype none

interface hbcd_req_if;
   import hbcd_pkg::*;

   logic    valid;
   logic    ready;
   req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> src/hbcd_rsp_if.sv
// hbcd_rsp_if: result item channel (valid/ready plus seven pixel colors).
// Depends on hbcd_pkg.
`default_nettype none

interface hbcd_rsp_if;
   import hbcd_pkg::*;

   logic    valid;
   logic    ready;
   rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> src/hires_byte_color_decode_core.sv
// hires_byte_color_decode_core: three-stage hi-res byte to pixel color decoder.
// Depends on hbcd_pkg, hbcd_req_if and hbcd_rsp_if.
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+-------------------------------------------
//  req_ch   | in  | valid/ready   | pattern_byte[7:0], column_odd
//  rsp_ch   | out | valid/ready   | pixel_color_0 .. pixel_color_6 [2:0]
//  csr_*    | in  | csr_wr_en     | csr_wr_data[1:0] = pix_mode
//
// An item passes the stage 1, 2 and 3 registers before it raises rsp_ch.valid;
// one item per cycle unless a low rsp_ch.ready stalls the output.
// Stage 1 builds raw hues/whites, stage 2 applies mono or the odd-position
// gap pass, stage 3 the even-position pass and drives the output register.
// Each stage holds its item while the next is full; ready ripples back from
// rsp_ch.ready, so a stall loses and repeats nothing.
// Synchronous reset clears all valid bits and sets pix_mode to plain color.
`default_nettype none

module hires_byte_color_decode_core (
   input  wire logic              clock,
   input  wire logic              reset,
   hbcd_req_if.sink               req_ch,
   hbcd_rsp_if.source             rsp_ch,
   input  wire logic              csr_wr_en,
   input  wire hbcd_pkg::mode_type csr_wr_data
);
   import hbcd_pkg::*;

   // config register
   mode_type    mode_ff, mode_in;

   // stage 1: raw colors
   logic        v1_ff, v1_in;
   pix_row_type px1_ff;
   color_type   fa1_ff, fb1_ff;   // first/second pass fill
   mode_type    m1_ff;

   // stage 2: mono or first gap pass
   logic        v2_ff, v2_in;
   pix_row_type px2_ff, px2_in;
   color_type   fb2_ff;
   mode_type    m2_ff;

   // stage 3: second gap pass, output register
   logic        v3_ff, v3_in;
   pix_row_type px3_ff, px3_in;

   logic        adv1, adv2, adv3;
   color_type   pg, pb;

   // a stage takes a new item when empty or when its item moves on
   assign adv3 = !v3_ff || rsp_ch.ready;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;
   assign req_ch.ready = adv1;

   assign mode_in = csr_wr_en ? csr_wr_data : mode_ff;
   assign v1_in   = adv1 ? req_ch.valid : v1_ff;
   assign v2_in   = adv2 ? v1_ff : v2_ff;
   assign v3_in   = adv3 ? v2_ff : v3_ff;

   assign pg = req_ch.data.pattern_byte[GROUP_BIT] ? C_RED  : C_GREEN;
   assign pb = req_ch.data.pattern_byte[GROUP_BIT] ? C_BLUE : C_PURPLE;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_RESET;
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         v3_ff   <= 1'b0;
      end else begin
         mode_ff <= mode_in;
         v1_ff   <= v1_in;
         v2_ff   <= v2_in;
         v3_ff   <= v3_in;
      end
   end

   // stage 1 payload
   always_ff @(posedge clock) begin
      if (adv1) begin
         px1_ff <= base_colors(req_ch.data.pattern_byte, req_ch.data.column_odd);
         fa1_ff <= req_ch.data.column_odd ? pg : pb;
         fb1_ff <= req_ch.data.column_odd ? pb : pg;
         m1_ff  <= mode_ff;
      end
   end

   // stage 2: odd positions only read even neighbors, which this pass keeps
   always_comb begin
      px2_in = px1_ff;
      if (m1_ff == MODE_MONO) begin
         for (int k = 0; k < PIX_COUNT; k++) begin
            if (px1_ff[k] != C_BLACK) px2_in[k] = C_WHITE;
         end
      end else if (m1_ff == MODE_INTERP) begin
         for (int k = 1; k <= 5; k += 2) begin
            if (px1_ff[k] == C_BLACK) begin
               px2_in[k] = gap_fill(px1_ff[k-1], px1_ff[k+1], fa1_ff);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv2) begin
         px2_ff <= px2_in;
         fb2_ff <= fb1_ff;
         m2_ff  <= m1_ff;
      end
   end

   // stage 3: positions 2 and 4 from the updated odd neighbors
   always_comb begin
      px3_in = px2_ff;
      if (m2_ff == MODE_INTERP) begin
         for (int k = 2; k <= 4; k += 2) begin
            if (px2_ff[k] == C_BLACK) begin
               px3_in[k] = gap_fill(px2_ff[k-1], px2_ff[k+1], fb2_ff);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv3) begin
         px3_ff <= px3_in;
      end
   end

   assign rsp_ch.valid              = v3_ff;
   assign rsp_ch.data.pixel_color_0 = px3_ff[0];
   assign rsp_ch.data.pixel_color_1 = px3_ff[1];
   assign rsp_ch.data.pixel_color_2 = px3_ff[2];
   assign rsp_ch.data.pixel_color_3 = px3_ff[3];
   assign rsp_ch.data.pixel_color_4 = px3_ff[4];
   assign rsp_ch.data.pixel_color_5 = px3_ff[5];
   assign rsp_ch.data.pixel_color_6 = px3_ff[6];

`ifndef SYNTH
   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> (!v1_ff && !v2_ff && !v3_ff))
      else $error("valid bits not cleared by reset");

   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      (v1_ff && !adv2) |=> (v1_ff && $stable(px1_ff)))
      else $error("stage 1 item dropped or changed during stall");

   a_mono_bw: assert property (@(posedge clock) disable iff (reset)
      (v2_ff && m2_ff == MODE_MONO) |->
         (px2_ff[0] <= C_WHITE && px2_ff[1] <= C_WHITE && px2_ff[2] <= C_WHITE &&
          px2_ff[3] <= C_WHITE && px2_ff[4] <= C_WHITE && px2_ff[5] <= C_WHITE &&
          px2_ff[6] <= C_WHITE))
      else $error("hue left in monochrome mode");

   a_color_range: assert property (@(posedge clock) disable iff (reset)
      v3_ff |->
         (px3_ff[0] <= C_RED && px3_ff[1] <= C_RED && px3_ff[2] <= C_RED &&
          px3_ff[3] <= C_RED && px3_ff[4] <= C_RED && px3_ff[5] <= C_RED &&
          px3_ff[6] <= C_RED))
      else $error("pixel color code out of range");
`endif

endmodule

`default_nettype wire
